FILE: design/rtd_pkg.sv
package rtd_pkg;

    // apb address width: six registers at byte addresses 0 to 20
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_MIN_PACK    = 3'd0;
    localparam logic [2:0] REG_PRE_PERIODS = 3'd1;
    localparam logic [2:0] REG_PRE_PERMIL  = 3'd2;
    localparam logic [2:0] REG_SAG_PERMIL  = 3'd3;
    localparam logic [2:0] REG_SAG_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_MAX_THROT   = 3'd5;

    // register reset values
    localparam logic [15:0] RST_MIN_PACK    = 16'd20000;
    localparam logic [15:0] RST_PRE_PERIODS = 16'd500;
    localparam logic [9:0]  RST_PRE_PERMIL  = 10'd900;
    localparam logic [9:0]  RST_SAG_PERMIL  = 10'd500;
    localparam logic [15:0] RST_SAG_TIMEOUT = 16'd100;
    localparam logic [11:0] RST_MAX_THROT   = 12'd200;

    // bus is in 0.1 V, pack in 0.01 V, ratio in per-mille
    localparam logic signed [14:0] BUS_SCALE = 15'sd10000;

    typedef struct packed {
        logic [15:0] min_pack_voltage;
        logic [15:0] precharge_periods;
        logic [9:0]  precharge_permille;
        logic [9:0]  sag_permille;
        logic [15:0] sag_timeout_periods;
        logic [11:0] max_throttle_ready;
    } t_cfg;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_INITIAL   = 7'b0000001,
        ST_VCHECK    = 7'b0000010,
        ST_WAIT      = 7'b0000100,
        ST_PRECHARGE = 7'b0001000,
        ST_BUSCHECK  = 7'b0010000,
        ST_NOTREADY  = 7'b0100000,
        ST_READY     = 7'b1000000
    } t_state;

    // reported state codes
    localparam logic [2:0] CODE_INITIAL   = 3'd0;
    localparam logic [2:0] CODE_VCHECK    = 3'd1;
    localparam logic [2:0] CODE_WAIT      = 3'd2;
    localparam logic [2:0] CODE_PRECHARGE = 3'd3;
    localparam logic [2:0] CODE_BUSCHECK  = 3'd4;
    localparam logic [2:0] CODE_NOTREADY  = 3'd5;
    localparam logic [2:0] CODE_READY     = 3'd6;

    function automatic logic [2:0] state_code(input t_state st);
        logic [2:0] code;
        case (st)
            ST_VCHECK:    code = CODE_VCHECK;
            ST_WAIT:      code = CODE_WAIT;
            ST_PRECHARGE: code = CODE_PRECHARGE;
            ST_BUSCHECK:  code = CODE_BUSCHECK;
            ST_NOTREADY:  code = CODE_NOTREADY;
            ST_READY:     code = CODE_READY;
            default:      code = CODE_INITIAL;
        endcase
        return code;
    endfunction

endpackage

FILE: design/rtd_regs.sv
module rtd_regs
    import rtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pack_voltage    <= RST_MIN_PACK;
            r_cfg.precharge_periods   <= RST_PRE_PERIODS;
            r_cfg.precharge_permille  <= RST_PRE_PERMIL;
            r_cfg.sag_permille        <= RST_SAG_PERMIL;
            r_cfg.sag_timeout_periods <= RST_SAG_TIMEOUT;
            r_cfg.max_throttle_ready  <= RST_MAX_THROT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_PACK:    r_cfg.min_pack_voltage    <= pwdata[15:0];
                REG_PRE_PERIODS: r_cfg.precharge_periods   <= pwdata[15:0];
                REG_PRE_PERMIL:  r_cfg.precharge_permille  <= pwdata[9:0];
                REG_SAG_PERMIL:  r_cfg.sag_permille        <= pwdata[9:0];
                REG_SAG_TIMEOUT: r_cfg.sag_timeout_periods <= pwdata[15:0];
                REG_MAX_THROT:   r_cfg.max_throttle_ready  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            REG_MIN_PACK:    prdata = {16'd0, r_cfg.min_pack_voltage};
            REG_PRE_PERIODS: prdata = {16'd0, r_cfg.precharge_periods};
            REG_PRE_PERMIL:  prdata = {22'd0, r_cfg.precharge_permille};
            REG_SAG_PERMIL:  prdata = {22'd0, r_cfg.sag_permille};
            REG_SAG_TIMEOUT: prdata = {16'd0, r_cfg.sag_timeout_periods};
            REG_MAX_THROT:   prdata = {20'd0, r_cfg.max_throttle_ready};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/precharge_ready_to_drive_sequencer.sv
// Precharge and ready-to-drive sequencer. Each request is one control period
// (pack voltage, both inverter bus voltages, precharge button, shutdown loop,
// throttle and its plausibility flag) and gives exactly one result: the
// sequencer state after that period, drive enable, the AIR2 command and the
// pump command. The edge that accepts a request registers the voltage
// products (bus x 10000 and pack x per-mille); the edge that moves it on,
// once the result slot is free, runs the ratio compares and the state
// update into the state registers that drive the result, which then holds
// there while the result side stalls. A new request is taken every cycle
// unless the result side stalls; one period's state update finishes before
// the next period reaches it. The user must write registers through the APB
// port only while no request is in flight; the block does not enforce it.
module precharge_ready_to_drive_sequencer
    import rtd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // apb register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [15:0]         i_pack_voltage,
    input  logic signed [15:0]  i_bus_voltage_left,
    input  logic signed [15:0]  i_bus_voltage_right,
    input  logic                i_precharge_button,
    input  logic                i_shutdown_closed,
    input  logic [11:0]         i_throttle_level,
    input  logic                i_throttle_ok,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_sequence_state,
    output logic                o_drive_enable,
    output logic                o_air2_closed,
    output logic                o_pumps_on
);

    t_cfg cfg;

    rtd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake and stage control
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s2_fire;
    logic accept;

    assign out_free = !r_out_valid || !i_stall;
    assign s2_fire  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage 1: scaled voltages and pack thresholds
    logic signed [30:0] r_left_x;
    logic signed [30:0] r_right_x;
    logic [25:0]        r_pack_pre;
    logic [25:0]        r_pack_sag;
    logic               r_button;
    logic               r_shutdown;
    logic [11:0]        r_throttle;
    logic               r_thr_ok;
    logic [15:0]        r_pack;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left_x   <= i_bus_voltage_left * BUS_SCALE;
            r_right_x  <= i_bus_voltage_right * BUS_SCALE;
            r_pack_pre <= i_pack_voltage * cfg.precharge_permille;
            r_pack_sag <= i_pack_voltage * cfg.sag_permille;
            r_pack     <= i_pack_voltage;
            r_button   <= i_precharge_button;
            r_shutdown <= i_shutdown_closed;
            r_throttle <= i_throttle_level;
            r_thr_ok   <= i_throttle_ok;
        end
    end

    // stage 2: ratio compares
    logic signed [30:0] pre_thr;
    logic signed [30:0] sag_thr;
    logic               pre_ok_l;
    logic               pre_ok_r;
    logic               sag_ok_l;
    logic               sag_ok_r;

    assign pre_thr  = $signed({5'd0, r_pack_pre});
    assign sag_thr  = $signed({5'd0, r_pack_sag});
    assign pre_ok_l = r_left_x >= pre_thr;
    assign pre_ok_r = r_right_x >= pre_thr;
    assign sag_ok_l = r_left_x >= sag_thr;
    assign sag_ok_r = r_right_x >= sag_thr;

    // sequencer state
    t_state      r_state;
    t_state      n_state;
    logic        r_contactor;
    logic        n_contactor;
    logic [15:0] r_pre_cnt;
    logic [15:0] n_pre_cnt;
    logic [15:0] r_sag_cnt;
    logic [15:0] n_sag_cnt;
    logic        r_sag_timing;
    logic        n_sag_timing;
    logic [15:0] pre_inc;
    logic [15:0] sag_inc;

    assign pre_inc = (r_pre_cnt == 16'hFFFF) ? r_pre_cnt : r_pre_cnt + 16'd1;
    assign sag_inc = (r_sag_cnt == 16'hFFFF) ? r_sag_cnt : r_sag_cnt + 16'd1;

    // next state for one control period
    always_comb begin
        n_state      = r_state;
        n_contactor  = r_contactor;
        n_pre_cnt    = r_pre_cnt;
        n_sag_cnt    = r_sag_cnt;
        n_sag_timing = r_sag_timing;
        case (r_state)
            ST_VCHECK: begin
                n_contactor = 1'b0;
                if (r_pack >= cfg.min_pack_voltage) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_contactor = 1'b0;
                if (r_button && r_shutdown) begin
                    n_state   = ST_PRECHARGE;
                    n_pre_cnt = '0;
                end
            end
            ST_PRECHARGE: begin
                n_contactor = 1'b0;
                n_pre_cnt   = pre_inc;
                if (pre_inc >= cfg.precharge_periods) begin
                    n_state = ST_BUSCHECK;
                end
            end
            ST_BUSCHECK: begin
                if (pre_ok_l && pre_ok_r) begin
                    n_state     = ST_NOTREADY;
                    n_contactor = 1'b1;
                end else begin
                    n_state     = ST_WAIT;
                    n_contactor = 1'b0;
                end
            end
            ST_NOTREADY: begin
                if (!pre_ok_l || !pre_ok_r) begin
                    n_state     = ST_WAIT;
                    n_contactor = 1'b0;
                end else if (r_thr_ok && (r_throttle < cfg.max_throttle_ready)) begin
                    n_state = ST_READY;
                end
            end
            ST_READY: begin
                if (!sag_ok_l && !sag_ok_r) begin
                    // sag: start or continue the timer
                    n_sag_timing = 1'b1;
                    n_sag_cnt    = r_sag_timing ? sag_inc : 16'd0;
                    if (n_sag_cnt >= cfg.sag_timeout_periods) begin
                        n_state      = ST_WAIT;
                        n_contactor  = 1'b0;
                        n_sag_timing = 1'b0;
                        n_sag_cnt    = '0;
                    end
                end else begin
                    n_sag_timing = 1'b0;
                    if (!r_thr_ok) begin
                        n_state     = ST_WAIT;
                        n_contactor = 1'b0;
                        n_sag_cnt   = '0;
                    end
                end
            end
            default: begin
                n_contactor = 1'b0;
                n_state     = ST_VCHECK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INITIAL;
            r_contactor  <= 1'b0;
            r_pre_cnt    <= '0;
            r_sag_cnt    <= '0;
            r_sag_timing <= 1'b0;
        end else if (s2_fire) begin
            r_state      <= n_state;
            r_contactor  <= n_contactor;
            r_pre_cnt    <= n_pre_cnt;
            r_sag_cnt    <= n_sag_cnt;
            r_sag_timing <= n_sag_timing;
        end
    end

    // result outputs follow the state, which only moves when the result slot is free
    assign o_valid          = r_out_valid;
    assign o_sequence_state = state_code(r_state);
    assign o_drive_enable   = (r_state == ST_READY);
    assign o_pumps_on       = (r_state == ST_READY);
    assign o_air2_closed    = r_contactor;

    // driving only with the contactor closed
    a_drive_air2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_drive_enable |-> o_air2_closed)
        else $error("drive enabled with air2 open");

    // sag timer runs only in ready to drive
    a_sag_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sag_timing |-> (r_state == ST_READY))
        else $error("sag timer active outside ready to drive");

    // contactor held open before the bus check
    a_open_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VCHECK || r_state == ST_WAIT || r_state == ST_PRECHARGE)
        |-> !r_contactor)
        else $error("contactor closed before bus check");

    // state moves only when a request passes into the result slot
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s2_fire |=> $stable(r_state) && $stable(r_contactor))
        else $error("state changed without a request");

endmodule
